/* hw/rtl/irpd_pkg.sv */
`timescale 1ns / 1ps

package irpd_pkg;

  localparam int unsigned TickWidth  = 16;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned FrameBits  = 32;
  localparam int unsigned BitIdxWidth = $clog2(FrameBits);
  localparam int unsigned CfgIdxWidth = 3;

  // Register indexes on the configuration port
  localparam logic [CfgIdxWidth-1:0] CFG_START     = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_REPEAT    = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_ONE       = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_ZERO      = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CFG_TOLERANCE = 3'd4;

  // Register values after reset
  localparam logic [TickWidth-1:0] START_RESET     = 16'd12442;
  localparam logic [TickWidth-1:0] REPEAT_RESET    = 16'd10368;
  localparam logic [TickWidth-1:0] ONE_RESET       = 16'd2074;
  localparam logic [TickWidth-1:0] ZERO_RESET      = 16'd1032;
  localparam logic [TickWidth-1:0] TOLERANCE_RESET = 16'd500;

  localparam logic [BitIdxWidth-1:0] LAST_BIT = BitIdxWidth'(FrameBits - 1);

  // Window hits of one edge interval, handed from front to back
  typedef struct packed {
    logic start_hit;
    logic repeat_hit;
    logic one_hit;
    logic zero_hit;
  } irpd_match_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LEADER = 3'b010,
    ST_DATA   = 3'b100
  } irpd_state_t;

endpackage

/* hw/rtl/ir_pulse_distance_frame_decoder.sv */
`timescale 1ns / 1ps

// Channel   Handshake                Payload
// cfg       cfg_valid / cfg_ready    cfg_index[2:0], cfg_data[15:0]
// in        in_valid / in_stall      interval[15:0]
// out       out_valid / out_stall    frame_valid, repeat_seen, address_out, command_out
//
// One edge per cycle sustained while out_stall is low; each accepted edge passes the
// window compare, a two-entry queue and the frame state step into the output register.
// cfg_ready is always high; configuration writes take effect on the next edge.
// Reset (rst, synchronous) restores the nominal windows and clears frame state.
// out_stall holds the output register; the queue then fills and raises in_stall.

module ir_pulse_distance_frame_decoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [irpd_pkg::CfgIdxWidth-1:0]  cfg_index,
  input  logic [irpd_pkg::TickWidth-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [irpd_pkg::TickWidth-1:0]    interval,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              frame_valid,
  output logic                              repeat_seen,
  output logic [irpd_pkg::ByteWidth-1:0]    address_out,
  output logic [irpd_pkg::ByteWidth-1:0]    command_out
);

  irpd_pkg::irpd_match_t push_data;
  irpd_pkg::irpd_match_t pop_data;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_not_empty;

  irpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .interval  (interval),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (push_data)
  );

  irpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_data)
  );

  irpd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (pop_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame_valid (frame_valid),
    .repeat_seen (repeat_seen),
    .address_out (address_out),
    .command_out (command_out)
  );

endmodule

/* hw/rtl/irpd_front.sv */
`timescale 1ns / 1ps

module irpd_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [irpd_pkg::CfgIdxWidth-1:0]    cfg_index,
  input  logic [irpd_pkg::TickWidth-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [irpd_pkg::TickWidth-1:0]      interval,
  input  logic                                q_full,
  output logic                                q_push,
  output irpd_pkg::irpd_match_t               q_data
);

  logic [irpd_pkg::TickWidth-1:0] start_ticks;
  logic [irpd_pkg::TickWidth-1:0] repeat_ticks;
  logic [irpd_pkg::TickWidth-1:0] one_ticks;
  logic [irpd_pkg::TickWidth-1:0] zero_ticks;
  logic [irpd_pkg::TickWidth-1:0] tolerance_ticks;

  // Inclusive window test without wrap: nom - tol <= x <= nom + tol
  function automatic logic in_window(input logic [irpd_pkg::TickWidth-1:0] x,
                                     input logic [irpd_pkg::TickWidth-1:0] nom,
                                     input logic [irpd_pkg::TickWidth-1:0] tol);
    logic [irpd_pkg::TickWidth:0] lo_sum;
    logic [irpd_pkg::TickWidth:0] hi_sum;
    lo_sum = {1'b0, x} + {1'b0, tol};
    hi_sum = {1'b0, nom} + {1'b0, tol};
    return (lo_sum >= {1'b0, nom}) && ({1'b0, x} <= hi_sum);
  endfunction

  assign cfg_ready = 1'b1;

  // Hold the window registers, update on a configuration request
  always_ff @(posedge clk) begin
    if (rst) begin
      start_ticks     <= irpd_pkg::START_RESET;
      repeat_ticks    <= irpd_pkg::REPEAT_RESET;
      one_ticks       <= irpd_pkg::ONE_RESET;
      zero_ticks      <= irpd_pkg::ZERO_RESET;
      tolerance_ticks <= irpd_pkg::TOLERANCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        irpd_pkg::CFG_START:     start_ticks     <= cfg_data;
        irpd_pkg::CFG_REPEAT:    repeat_ticks    <= cfg_data;
        irpd_pkg::CFG_ONE:       one_ticks       <= cfg_data;
        irpd_pkg::CFG_ZERO:      zero_ticks      <= cfg_data;
        irpd_pkg::CFG_TOLERANCE: tolerance_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify the interval against all four windows
  always_comb begin
    q_data.start_hit  = in_window(interval, start_ticks, tolerance_ticks);
    q_data.repeat_hit = in_window(interval, repeat_ticks, tolerance_ticks);
    q_data.one_hit    = in_window(interval, one_ticks, tolerance_ticks);
    q_data.zero_hit   = in_window(interval, zero_ticks, tolerance_ticks);
  end

  // Stall while the queue is full
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

/* hw/rtl/irpd_queue.sv */
`timescale 1ns / 1ps

module irpd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  irpd_pkg::irpd_match_t push_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output irpd_pkg::irpd_match_t pop_data
);

  irpd_pkg::irpd_match_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = entry[rd_ptr];

  // Write the classified request into the free slot
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      priority if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue occupancy out of range");
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
      push && !pop |=> count == $past(count) + 2'd1)
    else $error("queue count did not grow on push");
`endif

endmodule

/* hw/rtl/irpd_back.sv */
`timescale 1ns / 1ps

module irpd_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_not_empty,
  input  irpd_pkg::irpd_match_t             q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              frame_valid,
  output logic                              repeat_seen,
  output logic [irpd_pkg::ByteWidth-1:0]    address_out,
  output logic [irpd_pkg::ByteWidth-1:0]    command_out
);

  irpd_pkg::irpd_state_t state, state_next;
  logic [irpd_pkg::BitIdxWidth-1:0] bit_index, bit_index_next;
  logic [irpd_pkg::FrameBits-1:0]   frame_bits, frame_bits_next;
  logic [irpd_pkg::ByteWidth-1:0]   held_address, held_address_next;
  logic [irpd_pkg::ByteWidth-1:0]   held_command, held_command_next;
  logic                             valid_now;
  logic                             rep_now;
  logic                             bit_hit;

  // Take a request whenever the output register is free or draining
  assign q_pop   = q_not_empty && (!out_valid || !out_stall);
  assign bit_hit = q_data.one_hit || q_data.zero_hit;

  // Step the frame state on each request
  always_comb begin
    state_next        = state;
    bit_index_next    = bit_index;
    frame_bits_next   = frame_bits;
    held_address_next = held_address;
    held_command_next = held_command;
    valid_now         = 1'b0;
    rep_now           = 1'b0;
    if (q_pop) begin
      unique case (state)
        irpd_pkg::ST_LEADER: begin
          if (q_data.start_hit) begin
            state_next = irpd_pkg::ST_DATA;
          end else if (q_data.repeat_hit) begin
            rep_now    = 1'b1;
            state_next = irpd_pkg::ST_IDLE;
          end
        end
        irpd_pkg::ST_DATA: begin
          if (bit_hit) begin
            frame_bits_next[bit_index] = q_data.one_hit;
            if (bit_index == irpd_pkg::LAST_BIT) begin
              bit_index_next = '0;
              state_next     = irpd_pkg::ST_IDLE;
              // Latch only when each byte is the inverse of its partner
              if (frame_bits_next[7:0] == ~frame_bits_next[15:8] &&
                  frame_bits_next[23:16] == ~frame_bits_next[31:24]) begin
                held_address_next = frame_bits_next[7:0];
                held_command_next = frame_bits_next[23:16];
                valid_now         = 1'b1;
              end
            end else begin
              bit_index_next = bit_index + 1'b1;
            end
          end else begin
            // Drop the partial frame and look for a new leader
            bit_index_next = '0;
            state_next     = irpd_pkg::ST_LEADER;
          end
        end
        irpd_pkg::ST_IDLE: begin
          state_next = irpd_pkg::ST_LEADER;
        end
        default: begin
          state_next = irpd_pkg::ST_LEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= irpd_pkg::ST_IDLE;
      bit_index    <= '0;
      frame_bits   <= '0;
      held_address <= '0;
      held_command <= '0;
    end else begin
      state        <= state_next;
      bit_index    <= bit_index_next;
      frame_bits   <= frame_bits_next;
      held_address <= held_address_next;
      held_command <= held_command_next;
    end
  end

  // Output register: load on a request, clear once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      frame_valid <= valid_now;
      repeat_seen <= rep_now;
      address_out <= held_address_next;
      command_out <= held_command_next;
    end
  end

`ifndef ASSERT_OFF
  a_start_enters_data: assert property (@(posedge clk) disable iff (rst)
      q_pop && state == irpd_pkg::ST_LEADER && q_data.start_hit
      |=> state == irpd_pkg::ST_DATA && bit_index == '0)
    else $error("start leader did not enter data phase");
  a_last_bit_idles: assert property (@(posedge clk) disable iff (rst)
      q_pop && state == irpd_pkg::ST_DATA && bit_hit && bit_index == irpd_pkg::LAST_BIT
      |=> state == irpd_pkg::ST_IDLE && bit_index == '0)
    else $error("frame end did not return to idle");
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> !(frame_valid && repeat_seen))
    else $error("frame and repeat flagged together");
  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_stall |=> !$past(q_pop) && out_valid)
    else $error("result overwritten while stalled");
`endif

endmodule
